/* design/pspc_pkg.sv */
// Shared types and constants for the print stream page counter.
// Used by pspc_parser and print_stream_page_counter; no dependencies.
package pspc_pkg;

  localparam int CODE_W  = 13;
  localparam int BYTE_W  = 8;
  localparam int PAGE_W  = 17;
  localparam int DEPTH_W = 16;
  localparam int SKIP_W  = 24;
  localparam int LEN_W   = 2;
  localparam int OPHI_W  = 5;
  localparam int OUT_TDATA_W = 24;

  localparam int DEFAULT_HEADER_LIMIT = 256;
  localparam int DEFAULT_COUNT_BITS   = 16;

  localparam logic [CODE_W-1:0] BEGIN_BODY_RESET = 13'd90;
  localparam logic [CODE_W-1:0] END_BODY_RESET   = 13'd91;

  localparam logic [BYTE_W-1:0] SPACE_CHAR = 8'h20;

  // token tags, top three bits of a byte with bit 7 set
  localparam logic [2:0] TAG_SHORT_OP = 3'd4;
  localparam logic [2:0] TAG_LONG_OP  = 3'd5;
  localparam logic [2:0] TAG_SEQ_S    = 3'd6;
  localparam logic [2:0] TAG_SEQ_L    = 3'd7;

  localparam logic [LEN_W-1:0] SEQ_S_LEN_BYTES = 2'd1;
  localparam logic [LEN_W-1:0] SEQ_L_LEN_BYTES = 2'd3;

  // configuration register indexes
  localparam logic CFG_BEGIN_BODY = 1'b0;
  localparam logic CFG_END_BODY   = 1'b1;

  typedef enum logic [2:0] {
    MODE_HEADER,
    MODE_TOKEN,
    MODE_NUMLO,
    MODE_OPLO,
    MODE_LEN,
    MODE_SKIP
  } mode_t;

  typedef struct packed {
    logic              last;
    logic [PAGE_W-1:0] page_total;
    logic              truncated;
  } result_t;

endpackage

/* design/pspc_parser.sv */
// Byte tokenizer and body counter: header skip, token decode, nesting depth.
// Depends on pspc_pkg.
module pspc_parser #(
  parameter int HEADER_LIMIT = pspc_pkg::DEFAULT_HEADER_LIMIT,
  parameter int COUNT_BITS   = pspc_pkg::DEFAULT_COUNT_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step,
  input  logic [pspc_pkg::BYTE_W-1:0]   data_byte,
  input  logic                          final_byte,
  input  logic [pspc_pkg::CODE_W-1:0]   begin_code,
  input  logic [pspc_pkg::CODE_W-1:0]   end_code,
  output pspc_pkg::result_t             res
);
  import pspc_pkg::*;

  localparam int HDR_W = $clog2(HEADER_LIMIT + 1);
  localparam int EXT_W = (COUNT_BITS > PAGE_W) ? COUNT_BITS : PAGE_W;

  mode_t                 mode, mode_next;
  logic [HDR_W-1:0]      header_seen, header_seen_next;
  logic [OPHI_W-1:0]     op_hi, op_hi_next;
  logic [LEN_W-1:0]      len_left, len_left_next;
  logic [SKIP_W-1:0]     skip_rem, skip_rem_next;
  logic [DEPTH_W-1:0]    depth, depth_next;
  logic [COUNT_BITS-1:0] body_total, body_total_next;

  logic [CODE_W-1:0]     code;
  logic [EXT_W-1:0]      total_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_HEADER;
      header_seen <= '0;
      op_hi       <= '0;
      len_left    <= '0;
      skip_rem    <= '0;
      depth       <= '0;
      body_total  <= '0;
    end else if (step) begin
      if (final_byte) begin
        mode        <= MODE_HEADER;
        header_seen <= '0;
        op_hi       <= '0;
        len_left    <= '0;
        skip_rem    <= '0;
        depth       <= '0;
        body_total  <= '0;
      end else begin
        mode        <= mode_next;
        header_seen <= header_seen_next;
        op_hi       <= op_hi_next;
        len_left    <= len_left_next;
        skip_rem    <= skip_rem_next;
        depth       <= depth_next;
        body_total  <= body_total_next;
      end
    end
  end

  always_comb begin
    mode_next        = mode;
    header_seen_next = header_seen;
    op_hi_next       = op_hi;
    len_left_next    = len_left;
    skip_rem_next    = skip_rem;
    depth_next       = depth;
    body_total_next  = body_total;
    code             = {op_hi, data_byte};

    unique case (mode)
      MODE_HEADER: begin
        header_seen_next = header_seen + HDR_W'(1);
        if (data_byte == SPACE_CHAR || header_seen_next >= HDR_W'(HEADER_LIMIT))
          mode_next = MODE_TOKEN;
      end
      MODE_TOKEN: begin
        if (!data_byte[7]) begin
          mode_next = MODE_NUMLO;
        end else begin
          unique case (data_byte[7:5])
            TAG_LONG_OP: begin
              op_hi_next = data_byte[OPHI_W-1:0];
              mode_next  = MODE_OPLO;
            end
            TAG_SEQ_S: begin
              skip_rem_next = '0;
              len_left_next = SEQ_S_LEN_BYTES;
              mode_next     = MODE_LEN;
            end
            TAG_SEQ_L: begin
              skip_rem_next = '0;
              len_left_next = SEQ_L_LEN_BYTES;
              mode_next     = MODE_LEN;
            end
            default: ;  // short operator
          endcase
        end
      end
      MODE_NUMLO: mode_next = MODE_TOKEN;
      MODE_OPLO: begin
        // begin wins when both codes match
        if (code == begin_code) begin
          depth_next = depth + DEPTH_W'(1);
        end else if (code == end_code) begin
          depth_next = depth - DEPTH_W'(1);
          if (depth_next == '0 && !(&body_total))
            body_total_next = body_total + COUNT_BITS'(1);
        end
        mode_next = MODE_TOKEN;
      end
      MODE_LEN: begin
        skip_rem_next = {skip_rem[SKIP_W-BYTE_W-1:0], data_byte};
        len_left_next = len_left - LEN_W'(1);
        if (len_left_next == '0)
          mode_next = (skip_rem_next == '0) ? MODE_TOKEN : MODE_SKIP;
      end
      MODE_SKIP: begin
        if (skip_rem != '0)
          skip_rem_next = skip_rem - SKIP_W'(1);
        if (skip_rem_next == '0)
          mode_next = MODE_TOKEN;
      end
      default: mode_next = MODE_HEADER;
    endcase
  end

  assign total_ext = EXT_W'(body_total_next);

  always_comb begin
    res.last = final_byte;
    if (mode_next != MODE_TOKEN) begin
      res.page_total = '1;
      res.truncated  = 1'b1;
    end else begin
      res.page_total = PAGE_W'(total_ext - EXT_W'(1));
      res.truncated  = 1'b0;
    end
  end

endmodule

/* design/print_stream_page_counter.sv */
// Top level of the print stream page counter: stream ports, config registers,
// result register. Depends on pspc_pkg and pspc_parser.

// Takes one file byte per beat on the s_ side, s_tlast marking the file's
// last byte, and gives one beat on the m_ side per file: the count of
// top-level bodies minus one (signed, 17 bits, in m_tdata[16:0]) and in
// m_tuser a flag set when the file ended inside the header or a token, in
// which case the count reads -1. A byte is taken every cycle; the parser
// updates its state in the cycle the byte is accepted and the result is
// held in a single output register, so input stalls only while that
// register is full and m_tready is low. The body code registers are
// written through the cfg port (index 0 begin-body, index 1 end-body) and
// should change only between files.
module print_stream_page_counter #(
  parameter int HEADER_LIMIT = pspc_pkg::DEFAULT_HEADER_LIMIT,
  parameter int COUNT_BITS   = pspc_pkg::DEFAULT_COUNT_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [pspc_pkg::BYTE_W-1:0]        s_tdata,  // [7:0] data_byte
  input  logic                               s_tlast,  // final_byte
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [pspc_pkg::OUT_TDATA_W-1:0]   m_tdata,  // [16:0] page_total, rest zero
  output logic                               m_tuser,  // [0] truncated
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic                               cfg_index,
  input  logic [pspc_pkg::CODE_W-1:0]        cfg_data
);
  import pspc_pkg::*;

  logic [CODE_W-1:0] begin_code;
  logic [CODE_W-1:0] end_code;
  logic              step;
  result_t           res;
  logic [PAGE_W-1:0] page_total;
  logic              truncated;

  assign cfg_ready = 1'b1;
  assign s_tready  = !m_tvalid || m_tready;
  assign step      = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      begin_code <= BEGIN_BODY_RESET;
      end_code   <= END_BODY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_BEGIN_BODY: begin_code <= cfg_data;
        CFG_END_BODY:   end_code   <= cfg_data;
        default: ;
      endcase
    end
  end

  pspc_parser #(
    .HEADER_LIMIT(HEADER_LIMIT),
    .COUNT_BITS  (COUNT_BITS)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .data_byte (s_tdata),
    .final_byte(s_tlast),
    .begin_code(begin_code),
    .end_code  (end_code),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step) begin
      m_tvalid <= res.last;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res.last) begin
      page_total <= res.page_total;
      truncated  <= res.truncated;
    end
  end

  assign m_tdata = OUT_TDATA_W'(page_total);
  assign m_tuser = truncated;

endmodule
